// ----- rtl/aes_pkg.sv -----
package aes_pkg;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_in_upper;
    logic [63:0] block_in_lower;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] block_out_upper;
    logic [63:0] block_out_lower;
  } aes_out_t;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumWords  = 44;
  localparam logic [7:0]  GfPoly    = 8'h1b;

  localparam logic [0:0] RegKeyUpper = 1'd0;
  localparam logic [0:0] RegKeyLower = 1'd1;

  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    gf_dbl = {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ p;
      p = gf_dbl(p);
    end
    gf_mul = acc;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h01;
    p = x;
    for (int i = 1; i < 8; i++) begin
      p = gf_mul(p, p);
      r = gf_mul(r, p);
    end
    gf_inv = r;
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
    rol8 = (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = gf_inv(x);
    sbox_calc = b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] inv_sbox_calc(input logic [7:0] y);
    inv_sbox_calc = gf_inv(rol8(y, 1) ^ rol8(y, 3) ^ rol8(y, 6) ^ 8'h05);
  endfunction

  // Constant tables, evaluated at elaboration.
  typedef logic [7:0] sbox_arr_t [256];

  function automatic sbox_arr_t build_sbox(input logic inverse);
    sbox_arr_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inverse ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    build_sbox = t;
  endfunction

  localparam sbox_arr_t SboxFwd = build_sbox(1'b0);
  localparam sbox_arr_t SboxInv = build_sbox(1'b1);

  function automatic logic [7:0] rcon(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0: r = 8'h01;
      4'd1: r = 8'h02;
      4'd2: r = 8'h04;
      4'd3: r = 8'h08;
      4'd4: r = 8'h10;
      4'd5: r = 8'h20;
      4'd6: r = 8'h40;
      4'd7: r = 8'h80;
      4'd8: r = 8'h1b;
      4'd9: r = 8'h36;
      default: r = 8'h00;
    endcase
    rcon = r;
  endfunction

endpackage

// ----- rtl/aes_keyexp.sv -----
// Expands the key one round (four words) per cycle and writes the key memory.
module aes_keyexp (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] key,
  output logic         busy,
  output logic         wr_en,
  output logic [3:0]   wr_addr,
  output logic [127:0] wr_data
);
  import aes_pkg::*;

  logic [127:0] cur;
  logic [3:0]   rnd;
  logic         run;
  logic [31:0]  t;
  logic [31:0]  w0, w1, w2, w3;

  always_comb begin
    t  = {cur[23:0], cur[31:24]};
    t  = {SboxFwd[t[31:24]], SboxFwd[t[23:16]], SboxFwd[t[15:8]], SboxFwd[t[7:0]]};
    t  = t ^ {rcon(rnd - 4'd1), 24'h0};
    w0 = cur[127:96] ^ t;
    w1 = cur[95:64] ^ w0;
    w2 = cur[63:32] ^ w1;
    w3 = cur[31:0] ^ w2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      rnd <= 4'd0;
    end else if (start) begin
      run <= 1'b1;
      rnd <= 4'd1;
      cur <= key;
    end else if (run) begin
      cur <= {w0, w1, w2, w3};
      if (rnd == 4'(NumRounds)) run <= 1'b0;
      rnd <= rnd + 4'd1;
    end
  end

  assign busy    = run;
  assign wr_en   = start | run;
  assign wr_addr = start ? 4'd0 : rnd;
  assign wr_data = start ? key : {w0, w1, w2, w3};
endmodule

// ----- rtl/aes_round.sv -----
// One shared round: forward or inverse, with optional column mix.
module aes_round (
  input  logic         inverse,
  input  logic         do_mix,
  input  logic [127:0] st_in,
  input  logic [127:0] rk,
  output logic [127:0] st_out
);
  import aes_pkg::*;

  logic [7:0] s  [16];
  logic [7:0] sh [16];
  logic [7:0] sb [16];
  logic [7:0] ak [16];
  logic [7:0] mx [16];

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = st_in[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sh[4*c + r] = inverse ? s[4*((c - r + 4) % 4) + r] : s[4*((c + r) % 4) + r];
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[i] = inverse ? SboxInv[sh[i]] : SboxFwd[sh[i]];
      ak[i] = sb[i] ^ rk[127 - 8*i -: 8];
    end
    // Forward mixes before the key add; inverse mixes after it.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse) begin
          mx[4*c + r] = gf_mul(8'h0e, ak[4*c + r]) ^ gf_mul(8'h0b, ak[4*c + (r+1)%4]) ^
                        gf_mul(8'h0d, ak[4*c + (r+2)%4]) ^ gf_mul(8'h09, ak[4*c + (r+3)%4]);
        end else begin
          mx[4*c + r] = gf_dbl(sb[4*c + r]) ^ gf_mul(8'h03, sb[4*c + (r+1)%4]) ^
                        sb[4*c + (r+2)%4] ^ sb[4*c + (r+3)%4];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (!do_mix) st_out[127 - 8*i -: 8] = ak[i];
      else if (inverse) st_out[127 - 8*i -: 8] = mx[i];
      else st_out[127 - 8*i -: 8] = mx[i] ^ rk[127 - 8*i -: 8];
    end
  end
endmodule

// ----- rtl/aes128_block_cipher_core.sv -----
// AES-128 encrypt/decrypt core.
// Key: write key_upper (paddr 0) and key_lower (paddr 8) over the APB-style
// port. Each write re-expands the key into the round-key memory, one round
// key per cycle; the core is busy meanwhile.
// Data: pulse start with cmd while busy is low. kind 0 encrypts, 1 decrypts.
// Each block goes through the initial key add, ten passes through the
// shared round unit (one round per cycle), and one step to register the result.
// The result is registered on result, with done high for one cycle; the receiver
// cannot stall it. busy is high from the cycle after acceptance until done
// rises, so a new word can be accepted at the edge that ends the done cycle.
// Reset clears the control state and the key registers; the round-key memory
// holds nothing valid until the first key write.
module aes128_block_cipher_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  input  logic                start,
  input  aes_pkg::aes_in_t    cmd,
  output logic                busy,
  output logic                done,
  output aes_pkg::aes_out_t   result
);
  import aes_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DONE  = 3'b100
  } state_t;

  state_t       state;
  logic [63:0]  key_upper, key_lower;
  logic         cfg_wr;
  logic         kx_busy, kx_wr;
  logic [3:0]   kx_addr;
  logic [127:0] kx_data;
  logic [127:0] rk_mem [11];
  logic [127:0] rk;
  logic [127:0] st, st_rnd;
  logic [3:0]   rnd;
  logic         dec;
  logic [3:0]   rd_addr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3:3])
      RegKeyUpper: prdata = key_upper;
      RegKeyLower: prdata = key_lower;
      default:     prdata = 64'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= 64'h0;
      key_lower <= 64'h0;
    end else if (cfg_wr && paddr[3:3] == RegKeyUpper) begin
      key_upper <= pwdata;
    end else if (cfg_wr && paddr[3:3] == RegKeyLower) begin
      key_lower <= pwdata;
    end
  end

  logic         kx_start;
  logic [127:0] kx_key;
  always_comb begin
    kx_start = cfg_wr && (paddr[3:3] == RegKeyUpper || paddr[3:3] == RegKeyLower);
    kx_key   = (paddr[3:3] == RegKeyUpper) ? {pwdata, key_lower} : {key_upper, pwdata};
  end

  aes_keyexp u_kx (
    .clk(clk), .rst(rst), .start(kx_start), .key(kx_key), .busy(kx_busy),
    .wr_en(kx_wr), .wr_addr(kx_addr), .wr_data(kx_data)
  );

  always_ff @(posedge clk) begin
    if (kx_wr) rk_mem[kx_addr] <= kx_data;
  end

  // Round key for the next pass is read ahead into the rk register.
  always_comb begin
    if (state == S_IDLE) rd_addr = cmd.kind ? 4'd9 : 4'd1;
    else rd_addr = dec ? 4'd9 - rnd : rnd + 4'd1;
  end

  always_ff @(posedge clk) begin
    rk <= rk_mem[rd_addr];
  end

  aes_round u_rnd (
    .inverse(dec), .do_mix(rnd != 4'(NumRounds)), .st_in(st), .rk(rk), .st_out(st_rnd)
  );

  // Initial key add uses a direct memory read; only in idle.
  logic [127:0] rk0;
  assign rk0 = cmd.kind ? rk_mem[4'(NumRounds)] : rk_mem[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rnd   <= 4'd0;
      done  <= 1'b0;
      result <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && !kx_busy) begin
            st    <= {cmd.block_in_upper, cmd.block_in_lower} ^ rk0;
            dec   <= cmd.kind;
            rnd   <= 4'd1;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          st  <= st_rnd;
          rnd <= rnd + 4'd1;
          if (rnd == 4'(NumRounds)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          result <= {st[127:64], st[63:0]};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE) | kx_busy;
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import aes_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        start;
  aes_in_t     cmd;
  logic        busy;
  logic        done;
  aes_out_t    result;

  aes128_block_cipher_core uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .cmd(cmd), .busy(busy), .done(done), .result(result)
  );

  localparam int CycleLimit = 400000;

  // Predictor state: the key registers and the expanded schedule.
  logic [63:0] key_hi, key_lo;
  logic [31:0] sched [44];
  logic [7:0]  sb_fwd [256];
  logic [7:0]  sb_inv [256];

  aes_in_t  word_queue [$];
  aes_out_t expected_blocks [$];
  int       errors;
  int       cycles;
  int       send_gap;
  bit       no_idle;

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = xt(a);
    end
    return acc;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  task automatic build_tables();
    logic [7:0] inv, p, b;
    for (int x = 0; x < 256; x++) begin
      // Inverse as x^254, zero maps to zero.
      inv = 1;
      p = x[7:0];
      for (int i = 1; i < 8; i++) begin
        p = gmul(p, p);
        inv = gmul(inv, p);
      end
      b = inv ^ rotl(inv, 1) ^ rotl(inv, 2) ^ rotl(inv, 3) ^ rotl(inv, 4) ^ 8'h63;
      sb_fwd[x] = b;
    end
    for (int x = 0; x < 256; x++) sb_inv[sb_fwd[x]] = x[7:0];
  endtask

  task automatic expand_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    sched[0] = key_hi[63:32];
    sched[1] = key_hi[31:0];
    sched[2] = key_lo[63:32];
    sched[3] = key_lo[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sb_fwd[t[31:24]], sb_fwd[t[23:16]], sb_fwd[t[15:8]], sb_fwd[t[7:0]]};
        t ^= {rc, 24'h0};
        rc = xt(rc);
      end
      sched[i] = sched[i-4] ^ t;
    end
  endtask

  function automatic aes_out_t cipher_block(input aes_in_t w);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] col [4];
    logic [7:0] m [4];
    logic [127:0] blk;
    int rd;
    blk = {w.block_in_upper, w.block_in_lower};
    for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
    for (int s = 0; s < 11; s++) begin
      rd = w.kind ? 10 - s : s;
      if (s > 0) begin
        if (!w.kind) begin
          for (int i = 0; i < 16; i++) st[i] = sb_fwd[st[i]];
          for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) tmp[4*c+r] = st[4*((c+r)%4)+r];
          st = tmp;
          if (s < 10) begin
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
            for (int c = 0; c < 4; c++) begin
              for (int k = 0; k < 4; k++) col[k] = st[4*c+k];
              for (int r = 0; r < 4; r++) begin
                st[4*c+r] = 0;
                for (int k = 0; k < 4; k++) st[4*c+r] ^= gmul(m[(k-r+4)%4], col[k]);
              end
            end
          end
        end else begin
          for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) tmp[4*c+r] = st[4*((c-r+4)%4)+r];
          st = tmp;
          for (int i = 0; i < 16; i++) st[i] = sb_inv[st[i]];
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) st[4*c+r] ^= sched[4*rd+c][31-8*r -: 8];
      // Decryption applies InvMixColumns after the key add in rounds 9..1.
      if (w.kind && s > 0 && s < 10) begin
        m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        for (int c = 0; c < 4; c++) begin
          for (int k = 0; k < 4; k++) col[k] = st[4*c+k];
          for (int r = 0; r < 4; r++) begin
            st[4*c+r] = 0;
            for (int k = 0; k < 4; k++) st[4*c+r] ^= gmul(m[(k-r+4)%4], col[k]);
          end
        end
      end
    end
    for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = st[i];
    return '{block_out_upper: blk[127:64], block_out_lower: blk[63:0]};
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Driver: issues one queued word per accepted start, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
      send_gap <= 0;
    end else if (start && !busy) begin
      expected_blocks.push_back(cipher_block(cmd));
      start <= 0;
      if (!no_idle && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 12);
    end else if (!start) begin
      if (send_gap > 0) send_gap <= send_gap - 1;
      else if (word_queue.size() > 0 && !psel) begin
        cmd <= word_queue.pop_front();
        start <= 1;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors = errors + 1;
      end else begin
        if (result.block_out_upper !== expected_blocks[0].block_out_upper) begin
          $display("%0t: block_out_upper expected %h actual %h", $time,
                   expected_blocks[0].block_out_upper, result.block_out_upper);
          errors = errors + 1;
        end
        if (result.block_out_lower !== expected_blocks[0].block_out_lower) begin
          $display("%0t: block_out_lower expected %h actual %h", $time,
                   expected_blocks[0].block_out_lower, result.block_out_lower);
          errors = errors + 1;
        end
        void'(expected_blocks.pop_front());
      end
    end
    if (cycles > CycleLimit) begin
      $display("aes128_block_cipher_core regression: fail");
      $finish;
    end
  end

  task automatic write_key(input logic [3:0] addr, input logic [63:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == 4'd0) key_hi = val;
    else if (addr == 4'd8) key_lo = val;
    expand_schedule();
    // Let the key expansion finish before new words go out.
    repeat (16) @(posedge clk);
  endtask

  task automatic drain();
    wait (word_queue.size() == 0 && !start && expected_blocks.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic aes_in_t rand_word(input bit kind);
    aes_in_t w;
    w.kind = kind;
    w.block_in_upper = {$urandom(), $urandom()};
    w.block_in_lower = {$urandom(), $urandom()};
    return w;
  endfunction

  initial begin
    logic [63:0] ku, kl;
    errors = 0; cycles = 0; no_idle = 0;
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    cmd = '0; start = 0;
    key_hi = 0; key_lo = 0;
    build_tables();
    repeat (4) @(posedge clk);
    rst <= 0;
    // Known-answer vector from the standard first.
    write_key(4'd0, 64'h0001020304050607);
    write_key(4'd8, 64'h08090a0b0c0d0e0f);
    word_queue.push_back('{1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff});
    word_queue.push_back('{1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
    word_queue.push_back('{1'b0, '0, '0});
    word_queue.push_back('{1'b1, '1, '1});
    word_queue.push_back('{1'b0, '1, '1});
    word_queue.push_back('{1'b1, '0, '0});
    drain();
    // Key extremes, with only one half changed between some writes.
    write_key(4'd0, '0);
    write_key(4'd8, '0);
    for (int i = 0; i < 4; i++) word_queue.push_back(rand_word(i[0]));
    drain();
    write_key(4'd0, '1);
    for (int i = 0; i < 4; i++) word_queue.push_back(rand_word(i[0]));
    drain();
    write_key(4'd8, '1);
    for (int i = 0; i < 4; i++) word_queue.push_back(rand_word(i[0]));
    drain();
    // Random phases under fresh keys, each with random words of either kind;
    // the last phase sends with no random gaps.
    for (int ph = 0; ph < 12; ph++) begin
      ku = {$urandom(), $urandom()};
      kl = {$urandom(), $urandom()};
      write_key(4'd0, ku);
      write_key(4'd8, kl);
      if (ph == 11) no_idle = 1;
      for (int i = 0; i < 100; i++) word_queue.push_back(rand_word(1'($urandom_range(0, 1))));
      drain();
    end
    repeat (30) @(posedge clk);
    if (errors == 0 && expected_blocks.size() == 0)
      $display("aes128_block_cipher_core regression: pass");
    else
      $display("aes128_block_cipher_core regression: fail");
    $finish;
  end

endmodule
